FILE: src/weighted_history_track_gate_defines.svh
// Assertion macros used by the weighted history track gate top level.
`ifndef WEIGHTED_HISTORY_TRACK_GATE_DEFINES_SVH
`define WEIGHTED_HISTORY_TRACK_GATE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define WHTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define WHTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WHTG_ASSERT(lbl, prop, msg)
`define WHTG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/whtg_pkg.sv
// Shared constants and types for the weighted history track gate.
package whtg_pkg;

  // Default sizing
  localparam int HISTORY_MAX_DEF = 8;
  localparam int COORD_BITS_DEF  = 12;

  // Configuration register widths and port sizing
  localparam int TOL_W      = 12;
  localparam int DEPTH_W    = 4;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_DEPTH = 2'd2;

  // Configuration reset values
  localparam logic [TOL_W-1:0]   CENTER_TOL_RST = 12'd100;
  localparam logic [TOL_W-1:0]   SIZE_TOL_RST   = 12'd200;
  localparam logic [DEPTH_W-1:0] HIST_DEPTH_RST = 4'd5;

  // Lane codes for the four box fields
  localparam logic [1:0] FLD_X = 2'd0;
  localparam logic [1:0] FLD_Y = 2'd1;
  localparam logic [1:0] FLD_W = 2'd2;
  localparam logic [1:0] FLD_H = 2'd3;

  // Commands from the sequencer to the history store
  typedef struct packed {
    logic push;        // write a new newest box
    logic walk_start;  // point the read pointer at the newest box
    logic walk_step;   // read one box and move towards older ones
  } hist_ctrl_t;

endpackage

FILE: src/whtg_hist.sv
// Ring store of the newest boxes with fill count and walking read pointer.
module whtg_hist #(
  parameter int HISTORY_MAX = whtg_pkg::HISTORY_MAX_DEF,
  parameter int COORD_BITS  = whtg_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  whtg_pkg::hist_ctrl_t                ctrl_i,
  input  logic [whtg_pkg::DEPTH_W-1:0]        depth_i,
  input  logic [4*COORD_BITS-1:0]             box_i,
  output logic [$clog2(HISTORY_MAX+1)-1:0]    count_o,
  output logic [4*COORD_BITS-1:0]             rd_data_o
);
  import whtg_pkg::*;

  localparam int CNT_W  = $clog2(HISTORY_MAX + 1);
  localparam int SLOT_W = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
  localparam int BOX_W  = 4 * COORD_BITS;

  logic [BOX_W-1:0]  mem [HISTORY_MAX];
  logic [BOX_W-1:0]  rd_data_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] newest_q, newest_inc;
  logic [SLOT_W-1:0] rd_ptr_q, rd_ptr_dec;
  logic [CNT_W-1:0]  eff_depth;
  logic [CNT_W:0]    cnt_inc;

  // Clamp the configured depth into one to the store size
  always_comb begin
    if (depth_i == '0) begin
      eff_depth = CNT_W'(1);
    end else if ({1'b0, depth_i} > (DEPTH_W+1)'(HISTORY_MAX)) begin
      eff_depth = CNT_W'(HISTORY_MAX);
    end else begin
      eff_depth = CNT_W'(depth_i);
    end
  end

  // Advance the ring pointers with wrap at the store size
  assign newest_inc = (newest_q == SLOT_W'(HISTORY_MAX - 1)) ? '0 : newest_q + SLOT_W'(1);
  assign rd_ptr_dec = (rd_ptr_q == '0) ? SLOT_W'(HISTORY_MAX - 1) : rd_ptr_q - SLOT_W'(1);

  // Grow the count on a push, trimmed to the depth
  always_comb begin
    cnt_inc = (CNT_W+1)'(count_q) + (CNT_W+1)'(1);
    if (cnt_inc > {1'b0, eff_depth}) begin
      count_d = eff_depth;
    end else begin
      count_d = cnt_inc[CNT_W-1:0];
    end
  end

  // Hold the pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      newest_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (ctrl_i.push) begin
        count_q  <= count_d;
        newest_q <= newest_inc;
      end
      if (ctrl_i.walk_start) begin
        rd_ptr_q <= newest_q;
      end else if (ctrl_i.walk_step) begin
        rd_ptr_q <= rd_ptr_dec;
      end
    end
  end

  // Write the new box and read one box a cycle while the walk steps
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[newest_inc] <= box_i;
    end
    if (ctrl_i.walk_step) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  assign count_o   = count_q;
  assign rd_data_o = rd_data_q;

endmodule

FILE: src/whtg_div.sv
// Restoring divider, one quotient bit a cycle while busy, shared by the four averages.
module whtg_div #(
  parameter int COORD_BITS = whtg_pkg::COORD_BITS_DEF,
  parameter int WT_W       = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [COORD_BITS+WT_W-1:0] dividend_i,
  input  logic [WT_W-1:0]            divisor_i,
  output logic                       done_o,
  output logic [COORD_BITS-1:0]      quot_o
);
  import whtg_pkg::*;

  localparam int SUM_W = COORD_BITS + WT_W;
  localparam int CNT_W = $clog2(COORD_BITS + 1);

  logic [WT_W-1:0]       rem_q, rem_d;
  logic [COORD_BITS-1:0] low_q, low_d;
  logic [WT_W-1:0]       dvs_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [WT_W:0]         trial;
  logic [WT_W:0]         diff;
  logic                  ge;

  // One restoring step: the quotient stays below 2^COORD_BITS, so the
  // upper part of the dividend already lies below the divisor
  always_comb begin
    trial = {rem_q, low_q[COORD_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[WT_W-1:0] : trial[WT_W-1:0];
    low_d = {low_q[COORD_BITS-2:0], ge};
  end

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(COORD_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load the operands and shift the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[SUM_W-1:COORD_BITS];
      low_q <= dividend_i[COORD_BITS-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

FILE: src/weighted_history_track_gate.sv
// Top level: sequencer, weighted sum lanes, tolerance check and result register.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | kind_i, box_x_i, box_y_i,
//          |           |                          | box_width_i, box_height_i
//  out     | output    | out_valid_o / out_stall_i| matches_res_o, history_empty_o,
//          |           |                          | entries_held_o
//  cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// An add, or a query on an empty history, goes from acceptance straight to the finish state,
// whose output register then takes the valid result. A query over n boxes makes n reads of
// the history store, then runs the shared divider on each of the four sums in turn, then the
// tolerance check. One item is in work at a time; a stalled result holds the next item
// back only once the sequencer has finished it. Reset clears the count and pointers;
// the box store holds no reset value and needs no clearing pass.
`include "weighted_history_track_gate_defines.svh"

module weighted_history_track_gate #(
  parameter int HISTORY_MAX = whtg_pkg::HISTORY_MAX_DEF,
  parameter int COORD_BITS  = whtg_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [whtg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [whtg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [COORD_BITS-1:0]             box_x_i,
  input  logic [COORD_BITS-1:0]             box_y_i,
  input  logic [COORD_BITS-1:0]             box_width_i,
  input  logic [COORD_BITS-1:0]             box_height_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              matches_res_o,
  output logic                              history_empty_o,
  output logic [$clog2(HISTORY_MAX+1)-1:0]  entries_held_o
);
  import whtg_pkg::*;

  localparam int CNT_W  = $clog2(HISTORY_MAX + 1);
  localparam int BOX_W  = 4 * COORD_BITS;
  localparam int WT_MAX = HISTORY_MAX * (HISTORY_MAX + 1) / 2;
  localparam int WT_W   = $clog2(WT_MAX + 1);
  localparam int SUM_W  = COORD_BITS + WT_W;
  localparam int CMP_W  = (COORD_BITS + 1 > TOL_W) ? COORD_BITS + 1 : TOL_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_WALK     = 3'd1;
  localparam logic [2:0] ST_DIV_GO   = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT = 3'd3;
  localparam logic [2:0] ST_CMP      = 3'd4;
  localparam logic [2:0] ST_FIN      = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [TOL_W-1:0]      ctol_q, stol_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic [COORD_BITS-1:0] bx_q, by_q, bw_q, bh_q;
  logic [CNT_W-1:0]      iss_q, iss_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [1:0]            fld_q, fld_d;
  logic [SUM_W-1:0]      psum_q [4];
  logic [SUM_W-1:0]      wsum_q [4];
  logic [SUM_W-1:0]      psum_new [4];
  logic [COORD_BITS-1:0] lane_in [4];
  logic [WT_W-1:0]       pw_q, ww_q, pw_new;
  logic [COORD_BITS-1:0] avg_q [4];
  logic                  res_match_q, res_empty_q;
  logic                  out_valid_q;
  logic                  out_match_q, out_empty_q;
  logic [CNT_W-1:0]      out_held_q;
  logic                  acc;
  logic                  load_out;
  hist_ctrl_t            hctrl;
  logic [CNT_W-1:0]      hist_count;
  logic [BOX_W-1:0]      hist_rd;
  logic                  div_start;
  logic                  div_done;
  logic [COORD_BITS-1:0] div_quot;
  logic [CMP_W-1:0]      acx, acy, bcx, bcy, dcx, dcy, dw, dh;
  logic                  match_now;

  assign acc        = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign load_out   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // History store
  whtg_hist #(
    .HISTORY_MAX (HISTORY_MAX),
    .COORD_BITS  (COORD_BITS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hctrl),
    .depth_i   (depth_q),
    .box_i     ({box_x_i, box_y_i, box_width_i, box_height_i}),
    .count_o   (hist_count),
    .rd_data_o (hist_rd)
  );

  // Shared divider
  whtg_div #(
    .COORD_BITS (COORD_BITS),
    .WT_W       (WT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wsum_q[fld_q]),
    .divisor_i  (ww_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Step the sequencer
  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    rd_vld_d  = 1'b0;
    fld_d     = fld_q;
    hctrl     = '0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          fld_d = FLD_X;
          iss_d = hist_count;
          if (!kind_i) begin
            hctrl.push = 1'b1;
            state_d    = ST_FIN;
          end else if (hist_count == '0) begin
            state_d = ST_FIN;
          end else begin
            hctrl.walk_start = 1'b1;
            state_d          = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (iss_q != '0) begin
          hctrl.walk_step = 1'b1;
          iss_d           = iss_q - CNT_W'(1);
          rd_vld_d        = 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (fld_q == FLD_H) begin
            state_d = ST_CMP;
          end else begin
            fld_d   = fld_q + 2'd1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_CMP: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Form the next partial and weighted sums of each lane
  always_comb begin
    lane_in[FLD_X] = hist_rd[3*COORD_BITS +: COORD_BITS];
    lane_in[FLD_Y] = hist_rd[2*COORD_BITS +: COORD_BITS];
    lane_in[FLD_W] = hist_rd[COORD_BITS +: COORD_BITS];
    lane_in[FLD_H] = hist_rd[0 +: COORD_BITS];
    for (int l = 0; l < 4; l++) begin
      psum_new[l] = psum_q[l] + SUM_W'(lane_in[l]);
    end
    pw_new = pw_q + WT_W'(1);
  end

  // Check the queried box against the averaged box
  always_comb begin
    acx = CMP_W'(avg_q[FLD_X]) + CMP_W'(avg_q[FLD_W] >> 1);
    acy = CMP_W'(avg_q[FLD_Y]) + CMP_W'(avg_q[FLD_H] >> 1);
    bcx = CMP_W'(bx_q) + CMP_W'(bw_q >> 1);
    bcy = CMP_W'(by_q) + CMP_W'(bh_q >> 1);
    dcx = (acx >= bcx) ? acx - bcx : bcx - acx;
    dcy = (acy >= bcy) ? acy - bcy : bcy - acy;
    dw  = (CMP_W'(avg_q[FLD_W]) >= CMP_W'(bw_q)) ?
          CMP_W'(avg_q[FLD_W]) - CMP_W'(bw_q) : CMP_W'(bw_q) - CMP_W'(avg_q[FLD_W]);
    dh  = (CMP_W'(avg_q[FLD_H]) >= CMP_W'(bh_q)) ?
          CMP_W'(avg_q[FLD_H]) - CMP_W'(bh_q) : CMP_W'(bh_q) - CMP_W'(avg_q[FLD_H]);
    match_now = (dcx < CMP_W'(ctol_q)) && (dcy < CMP_W'(ctol_q)) &&
                (dw < CMP_W'(stol_q)) && (dh < CMP_W'(stol_q));
  end

  // Hold control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      fld_q       <= FLD_X;
      out_valid_q <= 1'b0;
      ctol_q      <= CENTER_TOL_RST;
      stol_q      <= SIZE_TOL_RST;
      depth_q     <= HIST_DEPTH_RST;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      rd_vld_q <= rd_vld_d;
      fld_q    <= fld_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CENTER_TOL: ctol_q  <= cfg_data_i[TOL_W-1:0];
          REG_SIZE_TOL:   stol_q  <= cfg_data_i[TOL_W-1:0];
          REG_HIST_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Capture the box, accumulate the lanes, collect quotients and results
  always_ff @(posedge clk_i) begin
    if (acc) begin
      bx_q        <= box_x_i;
      by_q        <= box_y_i;
      bw_q        <= box_width_i;
      bh_q        <= box_height_i;
      res_match_q <= 1'b0;
      res_empty_q <= (hist_count == '0);
      pw_q        <= '0;
      ww_q        <= '0;
      for (int l = 0; l < 4; l++) begin
        psum_q[l] <= '0;
        wsum_q[l] <= '0;
      end
    end
    if ((state_q == ST_WALK) && rd_vld_q) begin
      pw_q <= pw_new;
      ww_q <= ww_q + pw_new;
      for (int l = 0; l < 4; l++) begin
        psum_q[l] <= psum_new[l];
        wsum_q[l] <= wsum_q[l] + psum_new[l];
      end
    end
    if ((state_q == ST_DIV_WAIT) && div_done) begin
      avg_q[fld_q] <= div_quot;
    end
    if (state_q == ST_CMP) begin
      res_match_q <= match_now;
    end
    if (load_out) begin
      out_match_q <= res_match_q;
      out_empty_q <= res_empty_q;
      out_held_q  <= hist_count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign matches_res_o   = out_match_q;
  assign history_empty_o = out_empty_q;
  assign entries_held_o  = out_held_q;

  // Checks on the sequencer and the results
  `WHTG_ASSERT(a_count_bound, hist_count <= CNT_W'(HISTORY_MAX), "history count beyond store")
  `WHTG_ASSERT(a_match_nonempty, (out_valid_q && matches_res_o) |-> !history_empty_o, "match on empty history")
  `WHTG_ASSERT(a_held_nonzero, out_valid_q |-> ((entries_held_o != '0) || history_empty_o), "zero count after non-empty item")
  `WHTG_ASSERT(a_div_in_wait, div_done |-> (state_q == ST_DIV_WAIT), "divider finished outside wait state")
  `WHTG_ASSERT_NEXT(a_add_to_fin, acc && !kind_i, state_q == ST_FIN, "add did not finish at once")

endmodule
